>>> rtl/core/ttr_pkg.sv
// Shared types, constants and helpers of the tensor axis-swap index remapper.
package ttr_pkg;

   localparam int IDX_W         = 20;
   localparam int ELEM_W        = 32;
   localparam int SIZE_W        = 21;
   localparam int RANK_W        = 3;
   localparam int AXIS_W        = 2;
   localparam int NUM_SIZE_REGS = 4;
   localparam int CSR_IDX_W     = 3;
   localparam int CSR_DATA_W    = 21;
   // strides and counts saturate at 2^(IDX_W+1), above any index that can arrive
   localparam int CAP_W         = IDX_W + 2;
   localparam int MAX_DIMS_DEF  = 4;

   localparam logic [CAP_W-1:0] STRIDE_CAP = CAP_W'(1) << (IDX_W + 1);

   localparam logic [CSR_IDX_W-1:0] REG_RANK   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SIZE0  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SIZE1  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SIZE2  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SIZE3  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_AXIS_A = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_AXIS_B = 3'd6;

   typedef struct packed {
      logic [IDX_W-1:0]  source_index;
      logic [ELEM_W-1:0] element;
   } ttr_req_type;

   typedef struct packed {
      logic [IDX_W-1:0]  dest_index;
      logic [ELEM_W-1:0] element_out;
      logic              range_error;
   } ttr_rsp_type;

   // what travels alongside an item through the pipeline
   typedef struct packed {
      logic              valid;
      logic [IDX_W-1:0]  src;
      logic [ELEM_W-1:0] element;
      logic              err;
   } ttr_pass_type;

   function automatic logic [CAP_W-1:0] sat_mul(input logic [CAP_W-1:0] x,
                                                input logic [CAP_W-1:0] y);
      logic [2*CAP_W-1:0] p;
      p = x * y;
      if (p > {{CAP_W{1'b0}}, STRIDE_CAP}) begin
         return STRIDE_CAP;
      end
      return p[CAP_W-1:0];
   endfunction

endpackage

>>> rtl/core/ttr_stride.sv
// Configuration registers and registered stride chains of source and swapped shapes.
module ttr_stride #(
   parameter int MAX_DIMS = ttr_pkg::MAX_DIMS_DEF
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          csr_we,
   input  logic [ttr_pkg::CSR_IDX_W-1:0]                 csr_index,
   input  logic [ttr_pkg::CSR_DATA_W-1:0]                csr_wdata,
   output logic [MAX_DIMS-1:0][ttr_pkg::CAP_W-1:0]       src_stride,
   output logic [MAX_DIMS-1:0][ttr_pkg::CAP_W-1:0]       dst_stride,
   output logic [ttr_pkg::CAP_W-1:0]                     count,
   output logic                                          cfg_err,
   output logic [ttr_pkg::AXIS_W-1:0]                    axis_a,
   output logic [ttr_pkg::AXIS_W-1:0]                    axis_b
);
   import ttr_pkg::*;

   logic [RANK_W-1:0]  rank_ff;
   logic [SIZE_W-1:0]  size_ff [NUM_SIZE_REGS];
   logic [AXIS_W-1:0]  axis_a_ff;
   logic [AXIS_W-1:0]  axis_b_ff;

   logic [CAP_W-1:0] ext4 [NUM_SIZE_REGS];
   logic [CAP_W-1:0] ext_src [MAX_DIMS];
   logic [CAP_W-1:0] ext_dst [MAX_DIMS];
   logic [MAX_DIMS-1:0][CAP_W-1:0] sfx_src_ff;
   logic [MAX_DIMS-1:0][CAP_W-1:0] sfx_dst_ff;
   logic [CAP_W-1:0] count_ff;
   logic             cfg_err_ff;
   logic             cfg_err_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         rank_ff   <= RANK_W'(2);
         size_ff   <= '{default: SIZE_W'(1)};
         axis_a_ff <= AXIS_W'(0);
         axis_b_ff <= AXIS_W'(1);
      end else if (csr_we) begin
         unique case (csr_index)
            REG_RANK:   rank_ff    <= csr_wdata[RANK_W-1:0];
            REG_SIZE0:  size_ff[0] <= csr_wdata[SIZE_W-1:0];
            REG_SIZE1:  size_ff[1] <= csr_wdata[SIZE_W-1:0];
            REG_SIZE2:  size_ff[2] <= csr_wdata[SIZE_W-1:0];
            REG_SIZE3:  size_ff[3] <= csr_wdata[SIZE_W-1:0];
            REG_AXIS_A: axis_a_ff  <= csr_wdata[AXIS_W-1:0];
            REG_AXIS_B: axis_b_ff  <= csr_wdata[AXIS_W-1:0];
            default: ;
         endcase
      end
   end

   // extents beyond the rank count as one
   always_comb begin
      for (int d = 0; d < NUM_SIZE_REGS; d++) begin
         ext4[d] = (RANK_W'(d) < rank_ff) ? CAP_W'(size_ff[d]) : CAP_W'(1);
      end
   end

   for (genvar d = 0; d < MAX_DIMS; d++) begin : g_ext
      if (d < NUM_SIZE_REGS) begin : g_reg
         assign ext_src[d] = ext4[d];
         assign ext_dst[d] = (AXIS_W'(d) == axis_a_ff) ? ext4[axis_b_ff] :
                             (AXIS_W'(d) == axis_b_ff) ? ext4[axis_a_ff] : ext4[d];
      end else begin : g_one
         assign ext_src[d] = CAP_W'(1);
         assign ext_dst[d] = CAP_W'(1);
      end
   end

   assign cfg_err_in = (rank_ff == '0) || (int'(rank_ff) > NUM_SIZE_REGS) ||
                       (int'(rank_ff) > MAX_DIMS) ||
                       ({1'b0, axis_a_ff} >= rank_ff) || ({1'b0, axis_b_ff} >= rank_ff);

   // one multiply per register; after a write the chain settles from the last dimension towards count
   always_ff @(posedge clock) begin
      sfx_src_ff[MAX_DIMS-1] <= CAP_W'(1);
      sfx_dst_ff[MAX_DIMS-1] <= CAP_W'(1);
      for (int d = 0; d < MAX_DIMS - 1; d++) begin
         sfx_src_ff[d] <= sat_mul(sfx_src_ff[d+1], ext_src[d+1]);
         sfx_dst_ff[d] <= sat_mul(sfx_dst_ff[d+1], ext_dst[d+1]);
      end
      count_ff   <= sat_mul(sfx_src_ff[0], ext_src[0]);
      cfg_err_ff <= cfg_err_in;
   end

   assign src_stride = sfx_src_ff;
   assign dst_stride = sfx_dst_ff;
   assign count      = count_ff;
   assign cfg_err    = cfg_err_ff;
   assign axis_a     = axis_a_ff;
   assign axis_b     = axis_b_ff;

endmodule

>>> rtl/core/ttr_div_stage.sv
// One restoring-division step: one quotient bit of one coordinate per stage.
module ttr_div_stage #(
   parameter int MAX_DIMS = ttr_pkg::MAX_DIMS_DEF,
   parameter int DIM      = 0,
   parameter int BIT      = 0
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  ttr_pkg::ttr_pass_type                   pass_in,
   input  logic [ttr_pkg::IDX_W-1:0]               rem_in,
   input  logic [MAX_DIMS-1:0][ttr_pkg::IDX_W-1:0] coords_in,
   input  logic [ttr_pkg::CAP_W-1:0]               stride,
   output ttr_pkg::ttr_pass_type                   pass_out,
   output logic [ttr_pkg::IDX_W-1:0]               rem_out,
   output logic [MAX_DIMS-1:0][ttr_pkg::IDX_W-1:0] coords_out
);
   import ttr_pkg::*;

   ttr_pass_type                   pass_ff;
   logic [IDX_W-1:0]               rem_ff;
   logic [MAX_DIMS-1:0][IDX_W-1:0] coords_ff;
   logic [IDX_W-1:0]               rem_next_in;
   logic [MAX_DIMS-1:0][IDX_W-1:0] coords_next_in;
   logic                           take;
   logic [IDX_W-1:0]               rem_in_sh;

   assign rem_in_sh = rem_in >> BIT;
   // compare the shifted remainder so that stride << BIT never overflows
   assign take = {2'b00, rem_in_sh} >= stride;

   always_comb begin
      rem_next_in    = rem_in;
      coords_next_in = coords_in;
      if (take) begin
         rem_next_in              = rem_in - (stride[IDX_W-1:0] << BIT);
         coords_next_in[DIM][BIT] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pass_ff <= '0;
      end else begin
         pass_ff <= pass_in;
      end
      rem_ff    <= rem_next_in;
      coords_ff <= coords_next_in;
   end

   assign pass_out   = pass_ff;
   assign rem_out    = rem_ff;
   assign coords_out = coords_ff;

endmodule

>>> rtl/core/ttr_recompose.sv
// Recomposes the swapped coordinates with the destination strides and flags overflow.
module ttr_recompose #(
   parameter int MAX_DIMS = ttr_pkg::MAX_DIMS_DEF
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  ttr_pkg::ttr_pass_type                   pass_in,
   input  logic [MAX_DIMS-1:0][ttr_pkg::IDX_W-1:0] coords_in,
   input  logic [MAX_DIMS-1:0][ttr_pkg::CAP_W-1:0] dst_stride,
   output logic                                    rsp_valid,
   output ttr_pkg::ttr_rsp_type                    rsp_item
);
   import ttr_pkg::*;

   localparam int PROD_W = 2 * IDX_W + 1;
   localparam int SUM_W  = PROD_W + $clog2(MAX_DIMS) + 1;
   localparam logic [IDX_W:0] IDX_LIM = (IDX_W + 1)'(1) << IDX_W;

   ttr_pass_type     pass_a_ff;
   logic [PROD_W-1:0] prod_ff [MAX_DIMS];
   logic [IDX_W:0]    clamp [MAX_DIMS];
   logic [MAX_DIMS-1:0][IDX_W-1:0] swapped;
   logic [SUM_W-1:0]  sum;
   logic              over;
   logic              valid_ff;
   ttr_rsp_type       rsp_ff;

   // the two swap coordinates arrive already exchanged
   assign swapped = coords_in;

   always_comb begin
      for (int d = 0; d < MAX_DIMS; d++) begin
         clamp[d] = (dst_stride[d] > CAP_W'(IDX_LIM)) ? IDX_LIM : dst_stride[d][IDX_W:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pass_a_ff <= '0;
      end else begin
         pass_a_ff <= pass_in;
      end
      for (int d = 0; d < MAX_DIMS; d++) begin
         prod_ff[d] <= PROD_W'(swapped[d]) * PROD_W'(clamp[d]);
      end
   end

   always_comb begin
      sum = '0;
      for (int d = 0; d < MAX_DIMS; d++) begin
         sum = sum + SUM_W'(prod_ff[d]);
      end
      over = sum > SUM_W'({IDX_W{1'b1}});
   end

   always_ff @(posedge clock) begin
      valid_ff             <= pass_a_ff.valid && !reset;
      rsp_ff.element_out   <= pass_a_ff.element;
      rsp_ff.range_error   <= pass_a_ff.err || over;
      rsp_ff.dest_index    <= (pass_a_ff.err || over) ? pass_a_ff.src : sum[IDX_W-1:0];
   end

   assign rsp_valid = valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

>>> rtl/core/tensor_transpose_index_remap_top.sv
// Top level of the tensor axis-swap index remapper.
// Takes one index every cycle (start high, busy low) and returns its result, marked
// by rsp_valid for one cycle, after it has passed the entry line, the range check, the
// division stages and recomposition registers. The depth is set by the coordinate
// split, one quotient bit per stage for each dimension, plus a short entry line that
// lets the stride chain settle after a register write. There is no back-pressure:
// results must be taken when shown. busy is high only while reset is applied and in
// the cycle after. Registers are written through csr_we/csr_index/csr_wdata and must
// only be written with the pipeline empty.
module tensor_transpose_index_remap_top #(
   parameter int MAX_DIMS = ttr_pkg::MAX_DIMS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  ttr_pkg::ttr_req_type            req_item,
   output logic                            rsp_valid,
   output ttr_pkg::ttr_rsp_type            rsp_item,
   input  logic                            csr_we,
   input  logic [ttr_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [ttr_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import ttr_pkg::*;

   localparam int SETTLE  = MAX_DIMS + 3;
   localparam int NDIV    = MAX_DIMS * IDX_W;
   localparam int LATENCY = SETTLE + 1 + NDIV + 2;

   logic busy_ff;
   logic accept;

   logic [MAX_DIMS-1:0][CAP_W-1:0] src_stride;
   logic [MAX_DIMS-1:0][CAP_W-1:0] dst_stride;
   logic [CAP_W-1:0]               count;
   logic                           cfg_err;
   logic [AXIS_W-1:0]              axis_a;
   logic [AXIS_W-1:0]              axis_b;

   ttr_pass_type front_ff [SETTLE];
   ttr_pass_type front_in;

   ttr_pass_type                   node_pass   [NDIV+1];
   logic [IDX_W-1:0]               node_rem    [NDIV+1];
   logic [MAX_DIMS-1:0][IDX_W-1:0] node_coords [NDIV+1];
   ttr_pass_type                   chk_ff;
   ttr_pass_type                   chk_in;
   logic [IDX_W-1:0]               chk_rem_ff;
   logic [MAX_DIMS-1:0][IDX_W-1:0] swapped;

   always_ff @(posedge clock) begin
      busy_ff <= reset;
   end
   assign busy   = busy_ff || reset;
   assign accept = start && !busy;

   ttr_stride #(.MAX_DIMS(MAX_DIMS)) u_stride (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .src_stride (src_stride),
      .dst_stride (dst_stride),
      .count      (count),
      .cfg_err    (cfg_err),
      .axis_a     (axis_a),
      .axis_b     (axis_b)
   );

   assign front_in = '{valid: accept, src: req_item.source_index,
                       element: req_item.element, err: 1'b0};

   always_comb begin
      chk_in     = front_ff[SETTLE-1];
      chk_in.err = cfg_err || ({2'b00, front_ff[SETTLE-1].src} >= count);
   end

   // hold items in the entry line while the stride chain settles
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < SETTLE; s++) begin
            front_ff[s] <= '0;
         end
         chk_ff <= '0;
      end else begin
         front_ff[0] <= front_in;
         for (int s = 1; s < SETTLE; s++) begin
            front_ff[s] <= front_ff[s-1];
         end
         chk_ff <= chk_in;
      end
      chk_rem_ff <= front_ff[SETTLE-1].src;
   end

   assign node_pass[0]   = chk_ff;
   assign node_rem[0]    = chk_rem_ff;
   assign node_coords[0] = '0;

   for (genvar d = 0; d < MAX_DIMS; d++) begin : g_dim
      for (genvar k = 0; k < IDX_W; k++) begin : g_bit
         localparam int N = d * IDX_W + (IDX_W - 1 - k);
         ttr_div_stage #(.MAX_DIMS(MAX_DIMS), .DIM(d), .BIT(k)) u_div (
            .clock      (clock),
            .reset      (reset),
            .pass_in    (node_pass[N]),
            .rem_in     (node_rem[N]),
            .coords_in  (node_coords[N]),
            .stride     (src_stride[d]),
            .pass_out   (node_pass[N+1]),
            .rem_out    (node_rem[N+1]),
            .coords_out (node_coords[N+1])
         );
      end
   end

   // exchange the two swap coordinates before recomposition
   always_comb begin
      swapped = node_coords[NDIV];
      for (int d = 0; d < MAX_DIMS; d++) begin
         for (int s = 0; s < MAX_DIMS; s++) begin
            if (d < NUM_SIZE_REGS && s < NUM_SIZE_REGS) begin
               if (AXIS_W'(d) == axis_a && AXIS_W'(s) == axis_b) begin
                  swapped[d] = node_coords[NDIV][s];
               end else if (AXIS_W'(d) == axis_b && AXIS_W'(s) == axis_a) begin
                  swapped[d] = node_coords[NDIV][s];
               end
            end
         end
      end
   end

   ttr_recompose #(.MAX_DIMS(MAX_DIMS)) u_recompose (
      .clock        (clock),
      .reset        (reset),
      .pass_in      (node_pass[NDIV]),
      .coords_in    (swapped),
      .dst_stride   (dst_stride),
      .rsp_valid    (rsp_valid),
      .rsp_item     (rsp_item)
   );

   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, LATENCY))
      else $error("result strobe does not match an accepted beat");

   a_elem: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_item.element_out == $past(req_item.element, LATENCY))
      else $error("element bits altered");

   a_err_pass: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.range_error |->
         rsp_item.dest_index == $past(req_item.source_index, LATENCY))
      else $error("error beat does not pass the index through");

endmodule

>>> verif/tb_tensor_transpose_index_remap_top.sv
// Self-checking testbench for the tensor axis-swap index remapper.
module tb_tensor_transpose_index_remap_top;
   timeunit 1ns;
   timeprecision 1ps;

   import ttr_pkg::*;

   localparam longint unsigned SAT_LIMIT  = 64'd1 << 33;
   localparam longint unsigned IDX_MASK   = (64'd1 << IDX_W) - 1;
   localparam int              DRAIN_WAIT = 120;

   // Expected-remap store: keeps its own register copy and predicts each beat.
   class remap_scoreboard;
      bit [RANK_W-1:0]  rank_q;
      bit [SIZE_W-1:0]  extent_q [NUM_SIZE_REGS];
      bit [AXIS_W-1:0]  axis_a_q;
      bit [AXIS_W-1:0]  axis_b_q;
      ttr_rsp_type      expected_remaps [$];
      int               mismatches;

      function new();
         rank_q = 3'd2;
         foreach (extent_q[i]) extent_q[i] = 21'd1;
         axis_a_q = 2'd0;
         axis_b_q = 2'd1;
         mismatches = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            REG_RANK:   rank_q = data[RANK_W-1:0];
            REG_SIZE0:  extent_q[0] = data;
            REG_SIZE1:  extent_q[1] = data;
            REG_SIZE2:  extent_q[2] = data;
            REG_SIZE3:  extent_q[3] = data;
            REG_AXIS_A: axis_a_q = data[AXIS_W-1:0];
            REG_AXIS_B: axis_b_q = data[AXIS_W-1:0];
            default: ;
         endcase
      endfunction

      function longint unsigned capped_mul(longint unsigned x, longint unsigned y);
         if (x == 0 || y == 0) return 0;
         if (x >= SAT_LIMIT || y >= SAT_LIMIT) return SAT_LIMIT;
         if (x > SAT_LIMIT / y) return SAT_LIMIT;
         return (x * y > SAT_LIMIT) ? SAT_LIMIT : x * y;
      endfunction

      // element count of the shape in use, saturated
      function longint unsigned element_count();
         longint unsigned s;
         s = 1;
         for (int d = 0; d < rank_q && d < NUM_SIZE_REGS; d++)
            s = capped_mul(s, 64'(extent_q[d]));
         return s;
      endfunction

      function ttr_rsp_type remap(ttr_req_type r);
         ttr_rsp_type     res;
         longint unsigned ext [NUM_SIZE_REGS];
         longint unsigned src_str [NUM_SIZE_REGS];
         longint unsigned dst_str [NUM_SIZE_REGS];
         longint unsigned crd [NUM_SIZE_REGS];
         longint unsigned s, rest, dst, t;
         int n;
         bit too_wide;
         res.dest_index  = r.source_index;
         res.element_out = r.element;
         res.range_error = 1'b1;
         if (rank_q == 0 || rank_q > NUM_SIZE_REGS) return res;
         n = int'(rank_q);
         if (axis_a_q >= n || axis_b_q >= n) return res;
         for (int d = 0; d < n; d++) ext[d] = 64'(extent_q[d]);
         s = 1;
         for (int d = n - 1; d >= 0; d--) begin
            src_str[d] = s;
            s = capped_mul(s, ext[d]);
         end
         if (r.source_index >= s) return res;
         rest = 64'(r.source_index);
         for (int d = 0; d < n; d++) begin
            crd[d] = rest / src_str[d];
            rest   = rest % src_str[d];
         end
         t = ext[axis_a_q]; ext[axis_a_q] = ext[axis_b_q]; ext[axis_b_q] = t;
         t = crd[axis_a_q]; crd[axis_a_q] = crd[axis_b_q]; crd[axis_b_q] = t;
         s = 1;
         for (int d = n - 1; d >= 0; d--) begin
            dst_str[d] = s;
            s = capped_mul(s, ext[d]);
         end
         dst = 0;
         too_wide = 1'b0;
         for (int d = 0; d < n; d++) begin
            dst += capped_mul(crd[d], dst_str[d]);
            if (dst > IDX_MASK) too_wide = 1'b1;
         end
         if (too_wide) return res;
         res.dest_index  = dst[IDX_W-1:0];
         res.range_error = 1'b0;
         return res;
      endfunction

      function void note_request(ttr_req_type r);
         expected_remaps.push_back(remap(r));
      endfunction

      function void check_result(ttr_rsp_type got);
         ttr_rsp_type exp_rsp;
         if (expected_remaps.size() == 0) begin
            $error("unexpected result beat: dest_index %0d", got.dest_index);
            mismatches++;
            return;
         end
         exp_rsp = expected_remaps.pop_front();
         if (got.dest_index !== exp_rsp.dest_index) begin
            $error("dest_index: expected %0d, actual %0d", exp_rsp.dest_index, got.dest_index);
            mismatches++;
         end
         if (got.element_out !== exp_rsp.element_out) begin
            $error("element_out: expected %h, actual %h", exp_rsp.element_out,
                   got.element_out);
            mismatches++;
         end
         if (got.range_error !== exp_rsp.range_error) begin
            $error("range_error: expected %0b, actual %0b", exp_rsp.range_error,
                   got.range_error);
            mismatches++;
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   ttr_req_type           req_item;
   logic                  rsp_valid;
   ttr_rsp_type           rsp_item;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   remap_scoreboard sb = new();
   int              items_sent;
   bit              no_gaps;

   tensor_transpose_index_remap_top u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_item(req_item), .rsp_valid(rsp_valid), .rsp_item(rsp_item),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && start && !busy) sb.note_request(req_item);
      if (!reset && rsp_valid) sb.check_result(rsp_item);
   end

   initial begin
      #8ms;
      $display("Mismatches found");
      $finish;
   end

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      sb.write_reg(idx, data);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_shape(int rk, int s0, int s1, int s2, int s3, int ax_a, int ax_b);
      write_csr(REG_RANK, CSR_DATA_W'(rk));
      write_csr(REG_SIZE0, CSR_DATA_W'(s0));
      write_csr(REG_SIZE1, CSR_DATA_W'(s1));
      write_csr(REG_SIZE2, CSR_DATA_W'(s2));
      write_csr(REG_SIZE3, CSR_DATA_W'(s3));
      write_csr(REG_AXIS_A, CSR_DATA_W'(ax_a));
      write_csr(REG_AXIS_B, CSR_DATA_W'(ax_b));
   endtask

   // lower start and hold until every expected beat has come back
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (sb.expected_remaps.size() > 0) @(posedge clock);
   endtask

   task automatic send(logic [IDX_W-1:0] idx, logic [ELEM_W-1:0] elem);
      int gap;
      int roll;
      roll = $urandom_range(0, 99);
      if (no_gaps || roll < 50) gap = 0;
      else if (roll < 92) gap = $urandom_range(1, 3);
      else gap = $urandom_range(8, 40);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_item <= '{source_index: idx, element: elem};
      @(posedge clock);
      while (busy) @(posedge clock);
      items_sent++;
   endtask

   function automatic int pick_extent();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 80) return $urandom_range(1, 12);
      if (roll < 90) return $urandom_range(0, (1 << SIZE_W) - 1);
      case ($urandom_range(0, 3))
         0: return 0;
         1: return 1;
         2: return 1 << 20;
         default: return (1 << SIZE_W) - 1;
      endcase
   endfunction

   initial begin
      longint unsigned cnt;
      int rk;
      int phase_len;
      reset     = 1'b1;
      start     = 1'b0;
      req_item  = '0;
      csr_we    = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      items_sent = 0;
      no_gaps    = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset shape: a single element, anything else is out of range
      send(20'd0, 32'h0000_0000);
      send(20'd1, 32'hFFFF_FFFF);
      send(20'hFFFFF, 32'hA5A5_5A5A);
      drain();

      set_shape(4, 2, 3, 4, 5, 1, 3);
      send(20'd0, 32'h3F80_0000);
      send(20'd77, 32'h5A5A_A5A5);
      send(20'd119, 32'h7F80_0000);
      send(20'd120, 32'h1234_5678);
      drain();

      // equal axes give the identity
      set_shape(3, 3, 4, 5, 1, 2, 2);
      send(20'd59, 32'hDEAD_BEEF);
      send(20'd17, 32'h0BAD_F00D);
      drain();

      // axis beyond rank
      set_shape(3, 3, 4, 5, 1, 0, 3);
      send(20'd5, 32'h1111_1111);
      drain();

      // bad ranks
      write_csr(REG_RANK, CSR_DATA_W'(0));
      send(20'd0, 32'h2222_2222);
      drain();
      write_csr(REG_RANK, CSR_DATA_W'(5));
      send(20'd0, 32'h3333_3333);
      drain();
      write_csr(REG_RANK, CSR_DATA_W'(7));
      send(20'd3, 32'h4444_4444);
      drain();

      // zero extent: nothing in range
      set_shape(2, 0, 4, 1, 1, 0, 1);
      send(20'd0, 32'h5555_5555);
      drain();

      // remapped index too wide for the port
      set_shape(2, 2, 1 << 20, 1, 1, 1, 0);
      send(20'd1, 32'h6666_6666);
      send(20'hFFFFF, 32'h7777_7777);
      drain();

      set_shape(1, (1 << SIZE_W) - 1, 1, 1, 1, 0, 0);
      send(20'hFFFFF, 32'h8888_8888);
      send(20'h00000, 32'h9999_9999);
      drain();

      while (items_sent < 850) begin
         rk = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 4) : $urandom_range(0, 7);
         set_shape(rk, pick_extent(), pick_extent(), pick_extent(), pick_extent(),
                   ($urandom_range(0, 99) < 85 && rk > 0 && rk < 5) ?
                      $urandom_range(0, rk - 1) : $urandom_range(0, 3),
                   ($urandom_range(0, 99) < 85 && rk > 0 && rk < 5) ?
                      $urandom_range(0, rk - 1) : $urandom_range(0, 3));
         cnt       = sb.element_count();
         no_gaps   = ($urandom_range(0, 99) < 20);
         phase_len = $urandom_range(40, 100);
         for (int i = 0; i < phase_len; i++) begin
            if (cnt > 0 && $urandom_range(0, 99) < 85)
               send(IDX_W'((cnt > IDX_MASK) ? $urandom_range(0, IDX_MASK) : ($urandom % cnt)),
                    $urandom);
            else
               send(IDX_W'($urandom_range(0, IDX_MASK)), $urandom);
         end
         no_gaps = 1'b0;
         drain();
      end

      repeat (DRAIN_WAIT) @(posedge clock);
      if (sb.mismatches == 0 && sb.expected_remaps.size() == 0) begin
         $display("No mismatches found");
      end else begin
         if (sb.expected_remaps.size() > 0)
            $error("%0d expected beats never arrived", sb.expected_remaps.size());
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

>>> files.f
rtl/core/ttr_pkg.sv
rtl/core/ttr_stride.sv
rtl/core/ttr_div_stage.sv
rtl/core/ttr_recompose.sv
rtl/core/tensor_transpose_index_remap_top.sv
verif/tb_tensor_transpose_index_remap_top.sv
